// ===== src/fdrc_pkg.sv =====
// ----------------------------------------------------------------------------
// fdrc_pkg: shared types and constants for the framed datagram receiver
// Item types, status and phase codes, register indexes and the CRC-8 step.
// ----------------------------------------------------------------------------
package fdrc_pkg;

	localparam int unsigned MAX_FRAME_LENGTH_DEF = 8;

	localparam logic [7:0] START_BYTE_RST = 8'd17;
	localparam logic [7:0] CRC_POLY_RST   = 8'd140;

	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_START_BYTE = 1'b0,
		CFG_CRC_POLY   = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CRC      = 2'd1,
		ST_OVERFLOW = 2'd2
	} frame_status_t;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'b001,
		PH_LENGTH = 3'b010,
		PH_BODY   = 3'b100
	} phase_t;

	// Frame positions after the length byte
	localparam int unsigned IDX_ADDR      = 1;
	localparam int unsigned IDX_OPCODE    = 2;
	localparam int unsigned IDX_PAY_FIRST = 3;
	localparam int unsigned PAY_BYTES     = 4;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       rx_error;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  frame_status;
		logic [7:0]  frame_length;
		logic [7:0]  frame_address;
		logic [7:0]  frame_opcode;
		logic [31:0] frame_payload;
	} out_item_t;

	// Reflected CRC-8 over one byte: xor in, then eight shift steps
	function automatic logic [7:0] crc8_update(input logic [7:0] acc,
		input logic [7:0] data, input logic [7:0] poly);
		logic [7:0] a;
		a = acc ^ data;
		for (int k = 0; k < 8; k++) begin
			if (a[0]) begin
				a = (a >> 1) ^ poly;
			end else begin
				a = a >> 1;
			end
		end
		return a;
	endfunction

endpackage

// ===== src/framed_datagram_receiver_crc8_unit.sv =====
// ----------------------------------------------------------------------------
// framed_datagram_receiver_crc8_unit: length-prefixed frame receiver, CRC-8
// Hunts for the start byte, collects one frame and reports ok, CRC error or
// length overflow with address, opcode and up to four payload bytes.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input register, and its result, if any,
//   is then registered in the output register.
// Throughput: one item per cycle; the input register and the frame state
//   update hold only while a result waits in a stalled output register.
// Reset: phase returns to hunting, both stages empty, start_byte = 17 and
//   crc_poly = 140.
module framed_datagram_receiver_crc8_unit #(
	parameter int unsigned MAX_FRAME_LENGTH = fdrc_pkg::MAX_FRAME_LENGTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  fdrc_pkg::in_item_t                  in_item,
	output logic                                out_valid,
	input  logic                                out_stall,
	output fdrc_pkg::out_item_t                 out_item,
	input  logic                                cfg_we,
	input  logic [fdrc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [fdrc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int unsigned IDX_W = $clog2(MAX_FRAME_LENGTH);
	localparam int unsigned LEN_W = $clog2(MAX_FRAME_LENGTH + 1);

	logic [7:0] start_byte_q;
	logic [7:0] crc_poly_q;

	logic                valid_s1;
	fdrc_pkg::in_item_t  item_s1;

	fdrc_pkg::phase_t    phase_q, phase_d;
	logic [IDX_W-1:0]    idx_q, idx_d;
	logic [LEN_W-1:0]    len_q, len_d;
	logic [7:0]          crc_q, crc_d;
	logic [7:0]          addr_q, addr_d;
	logic [7:0]          opcode_q, opcode_d;
	logic [31:0]         payload_q, payload_d;

	logic                out_valid_q;
	fdrc_pkg::out_item_t out_item_q;

	logic                emit;
	fdrc_pkg::out_item_t result;
	logic [7:0]          data;
	logic                advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= fdrc_pkg::START_BYTE_RST;
			crc_poly_q   <= fdrc_pkg::CRC_POLY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fdrc_pkg::CFG_START_BYTE: start_byte_q <= cfg_data;
				fdrc_pkg::CFG_CRC_POLY:   crc_poly_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Frame logic on the registered item
	always_comb begin
		data      = item_s1.rx_error ? 8'd0 : item_s1.rx_byte;
		phase_d   = phase_q;
		idx_d     = idx_q;
		len_d     = len_q;
		crc_d     = crc_q;
		addr_d    = addr_q;
		opcode_d  = opcode_q;
		payload_d = payload_q;
		emit      = 1'b0;
		result    = '0;
		case (phase_q)
			fdrc_pkg::PH_LENGTH: begin
				addr_d    = 8'd0;
				opcode_d  = 8'd0;
				payload_d = 32'd0;
				if (data < 8'd2) begin
					phase_d             = fdrc_pkg::PH_HUNT;
					emit                = 1'b1;
					result.frame_status = fdrc_pkg::ST_CRC;
				end else if (data > 8'(MAX_FRAME_LENGTH)) begin
					phase_d             = fdrc_pkg::PH_HUNT;
					emit                = 1'b1;
					result.frame_status = fdrc_pkg::ST_OVERFLOW;
					result.frame_length = data - 8'd1;
				end else begin
					len_d   = data[LEN_W-1:0];
					crc_d   = fdrc_pkg::crc8_update(8'd0, data, crc_poly_q);
					idx_d   = IDX_W'(1);
					phase_d = fdrc_pkg::PH_BODY;
				end
			end
			fdrc_pkg::PH_BODY: begin
				if (8'(idx_q) + 8'd1 >= 8'(len_q)) begin
					// last byte is the CRC
					phase_d              = fdrc_pkg::PH_HUNT;
					idx_d                = '0;
					emit                 = 1'b1;
					result.frame_status  = (crc_q == data) ? fdrc_pkg::ST_OK
						: fdrc_pkg::ST_CRC;
					result.frame_length  = 8'(len_q) - 8'd1;
					result.frame_address = addr_q;
					result.frame_opcode  = opcode_q;
					result.frame_payload = payload_q;
				end else begin
					crc_d = fdrc_pkg::crc8_update(crc_q, data, crc_poly_q);
					idx_d = idx_q + IDX_W'(1);
					if (8'(idx_q) == 8'(fdrc_pkg::IDX_ADDR)) begin
						addr_d = data;
					end
					if (8'(idx_q) == 8'(fdrc_pkg::IDX_OPCODE)) begin
						opcode_d = data;
					end
					for (int k = 0; k < fdrc_pkg::PAY_BYTES; k++) begin
						if (8'(idx_q) == 8'(fdrc_pkg::IDX_PAY_FIRST + k)) begin
							payload_d[31-8*k -: 8] = payload_q[31-8*k -: 8] | data;
						end
					end
				end
			end
			default: begin
				phase_d = (data == start_byte_q) ? fdrc_pkg::PH_LENGTH
					: fdrc_pkg::PH_HUNT;
			end
		endcase
	end

	// Hold the item in stage 1 only when it has a result and the output is blocked
	assign advance  = !(valid_s1 && emit && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= fdrc_pkg::PH_HUNT;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (valid_s1 && advance) begin
				phase_q <= phase_d;
			end
			if (valid_s1 && advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_item;
		end
		if (valid_s1 && advance) begin
			idx_q     <= idx_d;
			len_q     <= len_d;
			crc_q     <= crc_d;
			addr_q    <= addr_d;
			opcode_q  <= opcode_d;
			payload_q <= payload_d;
		end
		if (valid_s1 && advance && emit) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && emit && out_valid_q && out_stall |-> in_stall)
		else $error("result would overwrite a waiting output item");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && emit && advance |=> out_valid_q)
		else $error("emitted result not held in output register");

	a_body_index: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == fdrc_pkg::PH_BODY |-> 8'(idx_q) < 8'(len_q))
		else $error("byte index ran past frame length");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_item_q.frame_status == fdrc_pkg::ST_OK
			|| out_item_q.frame_status == fdrc_pkg::ST_CRC
			|| out_item_q.frame_status == fdrc_pkg::ST_OVERFLOW))
		else $error("undefined frame status");

	a_overflow_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_item_q.frame_status == fdrc_pkg::ST_OVERFLOW
			|-> out_item_q.frame_length >= 8'(MAX_FRAME_LENGTH))
		else $error("overflow reported for a legal length");
`endif

endmodule

// ===== tb/sv/framed_datagram_receiver_crc8_unit_test.sv =====
// ----------------------------------------------------------------------------
// framed_datagram_receiver_crc8_unit_test: self-checking bench for the receiver
// Feeds framed byte streams (good, corrupted, bad length, noise) under random
// source gaps and sink stalls. A CRC-8 frame tracker predicts each result,
// and every delivered result is checked field by field.
// ----------------------------------------------------------------------------
module framed_datagram_receiver_crc8_unit_test;

	localparam int unsigned MAX_LEN         = fdrc_pkg::MAX_FRAME_LENGTH_DEF;
	localparam int unsigned QUIET_LIMIT     = 2000;
	localparam int unsigned SETTLE_CYCLES   = 4;
	localparam int unsigned BYTES_PER_PHASE = 206;
	localparam int unsigned CONFIG_PHASES   = 8;

	typedef fdrc_pkg::in_item_t item_q_t[$];

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	fdrc_pkg::in_item_t               in_item = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	fdrc_pkg::out_item_t              out_item;
	logic                             cfg_we = 1'b0;
	logic [fdrc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [fdrc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	// Register shadows, shared by the frame builder and the tracker
	logic [7:0] cfg_start = fdrc_pkg::START_BYTE_RST;
	logic [7:0] cfg_poly  = fdrc_pkg::CRC_POLY_RST;

	// Frame tracker state
	fdrc_pkg::phase_t rx_phase = fdrc_pkg::PH_HUNT;
	logic [3:0]  rx_index = '0;
	logic [7:0]  rx_len = '0;
	logic [7:0]  rx_crc = '0;
	logic [7:0]  rx_addr = '0;
	logic [7:0]  rx_opcode = '0;
	logic [31:0] rx_payload = '0;

	fdrc_pkg::in_item_t  rx_bytes_pending[$];
	fdrc_pkg::out_item_t frames_expected[$];
	int unsigned frame_bytes = 0;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned in_wait_left = 0;
	int unsigned out_hold_left = 0;
	bit          in_calm = 1'b0;
	bit          out_calm = 1'b0;
	logic        in_taken = 1'b0;
	logic        out_taken = 1'b0;

	framed_datagram_receiver_crc8_unit #(
		.MAX_FRAME_LENGTH(MAX_LEN)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	function automatic logic [7:0] crc8_reflect(input logic [7:0] acc,
		input logic [7:0] data, input logic [7:0] poly);
		logic [7:0] a;
		a = acc ^ data;
		repeat (8) begin
			a = a[0] ? ((a >> 1) ^ poly) : (a >> 1);
		end
		return a;
	endfunction

	function automatic int unsigned idle_draw(input bit calm);
		return calm ? 0 : $urandom_range(0, 14);
	endfunction

	// Advance the frame tracker by one byte; return 1 when a frame result is due
	function automatic bit track_rx_byte(input fdrc_pkg::in_item_t item,
		output fdrc_pkg::out_item_t res);
		logic [7:0] b;
		bit done;
		b = item.rx_error ? 8'h00 : item.rx_byte;
		res = '0;
		done = 1'b0;
		case (rx_phase)
			fdrc_pkg::PH_LENGTH: begin
				rx_addr = '0;
				rx_opcode = '0;
				rx_payload = '0;
				rx_len = b;
				if (b < 8'd2) begin
					rx_phase = fdrc_pkg::PH_HUNT;
					res.frame_status = fdrc_pkg::ST_CRC;
					res.frame_length = (b == 8'd0) ? 8'd0 : b - 8'd1;
					done = 1'b1;
				end else if (int'(b) > int'(MAX_LEN)) begin
					rx_phase = fdrc_pkg::PH_HUNT;
					res.frame_status = fdrc_pkg::ST_OVERFLOW;
					res.frame_length = b - 8'd1;
					done = 1'b1;
				end else begin
					rx_crc = crc8_reflect(8'h00, b, cfg_poly);
					rx_index = 4'd1;
					rx_phase = fdrc_pkg::PH_BODY;
				end
			end
			fdrc_pkg::PH_BODY: begin
				if (int'(rx_index) + 1 >= int'(rx_len)) begin
					// last byte carries the CRC
					rx_phase = fdrc_pkg::PH_HUNT;
					rx_index = '0;
					res.frame_status = (rx_crc == b) ? fdrc_pkg::ST_OK
						: fdrc_pkg::ST_CRC;
					res.frame_length = rx_len - 8'd1;
					res.frame_address = rx_addr;
					res.frame_opcode = rx_opcode;
					res.frame_payload = rx_payload;
					done = 1'b1;
				end else begin
					rx_crc = crc8_reflect(rx_crc, b, cfg_poly);
					if (rx_index == fdrc_pkg::IDX_ADDR) begin
						rx_addr = b;
					end else if (rx_index == fdrc_pkg::IDX_OPCODE) begin
						rx_opcode = b;
					end else if (rx_index >= fdrc_pkg::IDX_PAY_FIRST &&
						rx_index < fdrc_pkg::IDX_PAY_FIRST + fdrc_pkg::PAY_BYTES) begin
						rx_payload |= 32'(b) << (8 * (fdrc_pkg::IDX_PAY_FIRST
							+ fdrc_pkg::PAY_BYTES - 1 - int'(rx_index)));
					end
					rx_index = rx_index + 4'd1;
				end
			end
			default: begin
				rx_phase = (b == cfg_start) ? fdrc_pkg::PH_LENGTH : fdrc_pkg::PH_HUNT;
			end
		endcase
		return done;
	endfunction

	// Queue start and length byte, then body and CRC byte for a legal length; body must hold length-2 bytes
	task automatic send_frame(input logic [7:0] len_val, input bit len_err,
		input item_q_t body, input bit bad_crc);
		fdrc_pkg::in_item_t item;
		logic [7:0] len_eff;
		logic [7:0] acc;
		item.rx_byte = cfg_start;
		item.rx_error = 1'b0;
		if (cfg_start == 8'h00 && $urandom_range(0, 1) == 1) begin
			item.rx_byte = 8'($urandom_range(0, 255));
			item.rx_error = 1'b1;
		end
		rx_bytes_pending.push_back(item);
		item.rx_byte = len_val;
		item.rx_error = len_err;
		rx_bytes_pending.push_back(item);
		frame_bytes += 2;
		len_eff = len_err ? 8'h00 : len_val;
		if (len_eff >= 8'd2 && int'(len_eff) <= int'(MAX_LEN)) begin
			acc = crc8_reflect(8'h00, len_eff, cfg_poly);
			foreach (body[i]) begin
				rx_bytes_pending.push_back(body[i]);
				acc = crc8_reflect(acc, body[i].rx_error ? 8'h00 : body[i].rx_byte, cfg_poly);
			end
			item.rx_error = 1'b0;
			item.rx_byte = bad_crc ? (acc ^ 8'($urandom_range(1, 255))) : acc;
			rx_bytes_pending.push_back(item);
			frame_bytes += body.size() + 1;
		end
	endtask

	task automatic write_reg(input fdrc_pkg::cfg_reg_t idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			fdrc_pkg::CFG_START_BYTE: cfg_start = val;
			fdrc_pkg::CFG_CRC_POLY:   cfg_poly = val;
			default: ;
		endcase
	endtask

	task automatic drain_and_settle();
		while (rx_bytes_pending.size() != 0 || in_valid || frames_expected.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	always @(negedge clk) begin : byte_driver
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (in_wait_left != 0) begin
					in_valid <= 1'b0;
					in_wait_left <= in_wait_left - 1;
				end else if (rx_bytes_pending.size() != 0) begin
					in_item <= rx_bytes_pending.pop_front();
					in_valid <= 1'b1;
					in_wait_left <= idle_draw(in_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin : result_sink
		int unsigned hold;
		if (arst_n) begin
			if (out_taken) begin
				hold = idle_draw(out_calm);
				out_hold_left <= hold;
				out_stall <= (hold != 0);
			end else if (out_valid && out_hold_left != 0) begin
				out_hold_left <= out_hold_left - 1;
				out_stall <= (out_hold_left > 1);
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		fdrc_pkg::out_item_t predicted;
		fdrc_pkg::out_item_t want;
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			out_taken <= out_valid && !out_stall;
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (in_valid && !in_stall) begin
				if (track_rx_byte(in_item, predicted)) begin
					frames_expected.push_back(predicted);
				end
			end
			if (out_valid && !out_stall) begin
				if (frames_expected.size() == 0) begin
					$error("result with nothing expected: status %0d length %0d",
						out_item.frame_status, out_item.frame_length);
					mismatch_count++;
				end else begin
					want = frames_expected.pop_front();
					if (out_item.frame_status !== want.frame_status) begin
						$error("frame_status: expected %0d, got %0d",
							want.frame_status, out_item.frame_status);
						mismatch_count++;
					end
					if (out_item.frame_length !== want.frame_length) begin
						$error("frame_length: expected %0d, got %0d",
							want.frame_length, out_item.frame_length);
						mismatch_count++;
					end
					if (out_item.frame_address !== want.frame_address) begin
						$error("frame_address: expected %0h, got %0h",
							want.frame_address, out_item.frame_address);
						mismatch_count++;
					end
					if (out_item.frame_opcode !== want.frame_opcode) begin
						$error("frame_opcode: expected %0h, got %0h",
							want.frame_opcode, out_item.frame_opcode);
						mismatch_count++;
					end
					if (out_item.frame_payload !== want.frame_payload) begin
						$error("frame_payload: expected %0h, got %0h",
							want.frame_payload, out_item.frame_payload);
						mismatch_count++;
					end
				end
			end
		end else begin
			in_taken <= 1'b0;
			out_taken <= 1'b0;
		end
	end

	initial begin : watchdog
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		item_q_t body;
		fdrc_pkg::in_item_t one;
		int unsigned pick;
		int unsigned n;
		logic [7:0] len;
		logic [7:0] start_val;
		logic [7:0] poly_val;
		bit len_err;
		while (!arst_n) begin
			@(negedge clk);
		end

		// Directed frames under reset settings
		body.delete();
		send_frame(8'hAB, 1'b1, body, 1'b0);        // flagged length byte reads as zero
		send_frame(8'd1, 1'b0, body, 1'b0);
		send_frame(8'd2, 1'b0, body, 1'b0);         // CRC byte only
		send_frame(8'(MAX_LEN + 1), 1'b0, body, 1'b0);
		send_frame(8'd255, 1'b0, body, 1'b0);
		// full frame: extremes, a flagged byte and the start byte as data
		body = '{{8'hFF, 1'b0}, {8'hFF, 1'b1}, {fdrc_pkg::START_BYTE_RST, 1'b0},
			{8'h80, 1'b0}, {8'h01, 1'b0}, {8'h5A, 1'b0}};
		send_frame(8'(MAX_LEN), 1'b0, body, 1'b0);
		body = '{{8'hC3, 1'b0}};
		send_frame(8'd3, 1'b0, body, 1'b1);

		for (int p = 0; p < CONFIG_PHASES; p++) begin
			drain_and_settle();
			case (p)
				0: begin start_val = 8'h00; poly_val = 8'h00; end
				1: begin start_val = 8'hFF; poly_val = 8'hFF; end
				2: begin
					start_val = fdrc_pkg::START_BYTE_RST;
					poly_val = fdrc_pkg::CRC_POLY_RST;
				end
				3: begin start_val = 8'h00; poly_val = fdrc_pkg::CRC_POLY_RST; end
				4: begin start_val = 8'hFF; poly_val = 8'h00; end
				default: begin
					start_val = 8'($urandom_range(0, 255));
					poly_val = 8'($urandom_range(0, 255));
				end
			endcase
			write_reg(fdrc_pkg::CFG_START_BYTE, start_val);
			write_reg(fdrc_pkg::CFG_CRC_POLY, poly_val);
			@(negedge clk);
			cfg_we <= 1'b0;
			in_calm = ($urandom_range(0, 3) == 0);
			out_calm = ($urandom_range(0, 3) == 0);
			frame_bytes = 0;
			while (frame_bytes < BYTES_PER_PHASE) begin
				pick = $urandom_range(0, 19);
				body.delete();
				if (pick < 2) begin
					// line noise between frames
					n = $urandom_range(1, 3);
					repeat (n) begin
						one.rx_byte = 8'($urandom_range(0, 255));
						one.rx_error = ($urandom_range(0, 3) == 0);
						rx_bytes_pending.push_back(one);
					end
				end else if (pick < 4) begin
					len_err = 1'b0;
					case ($urandom_range(0, 3))
						0: begin len = 8'($urandom_range(0, 255)); len_err = 1'b1; end
						1: len = 8'd1;
						2: len = 8'd255;
						default: len = 8'($urandom_range(MAX_LEN + 1, 255));
					endcase
					send_frame(len, len_err, body, 1'b0);
				end else begin
					len = 8'($urandom_range(2, MAX_LEN));
					repeat (int'(len) - 2) begin
						one.rx_byte = 8'($urandom_range(0, 255));
						one.rx_error = ($urandom_range(0, 15) == 0);
						body.push_back(one);
					end
					send_frame(len, 1'b0, body, pick < 7);
				end
			end
		end

		drain_and_settle();
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/fdrc_pkg.sv
src/framed_datagram_receiver_crc8_unit.sv
tb/sv/framed_datagram_receiver_crc8_unit_test.sv
